FILE: design/phv2_pkg.sv
package phv2_pkg;

  localparam int unsigned QDepthDefault = 4;

  typedef enum logic [3:0] {
    K_SIG = 4'd0, K_CMD = 4'd1, K_FAM = 4'd2, K_LEN = 4'd3, K_SRC = 4'd4,
    K_DST = 4'd5, K_SPORT = 4'd6, K_DPORT = 4'd7, K_TTYPE = 4'd8,
    K_TLEN = 4'd9, K_TVAL = 4'd10, K_IGN = 4'd11, K_PAY = 4'd12
  } kind_t;

  typedef enum logic [3:0] {
    S_PEND = 4'd0, S_PROXY = 4'd1, S_LOCAL = 4'd2, S_NOSIG = 4'd3,
    S_BADCMD = 4'd4, S_BADFAM = 4'd5, S_SHORT = 4'd6, S_TLVSHORT = 4'd7,
    S_TLVOVR = 4'd8, S_TRUNC = 4'd9
  } status_t;

  localparam logic [7:0] CMD_LOCAL  = 8'h20;
  localparam logic [7:0] CMD_PROXY  = 8'h21;
  localparam logic [7:0] FAM_UNSPEC = 8'h00;
  localparam logic [7:0] FAM_TCP4   = 8'h11;
  localparam logic [7:0] FAM_UDP4   = 8'h12;
  localparam logic [7:0] FAM_TCP6   = 8'h21;
  localparam logic [7:0] FAM_UDP6   = 8'h22;
  localparam logic [16:0] ADDR_LEN_V4 = 17'd12;
  localparam logic [16:0] ADDR_LEN_V6 = 17'd36;
  localparam logic [16:0] FIXED_LEN   = 17'd16;

  function automatic logic [7:0] sig_byte(input logic [3:0] i);
    case (i)
      4'd0: sig_byte = 8'h0D;
      4'd1: sig_byte = 8'h0A;
      4'd2: sig_byte = 8'h0D;
      4'd3: sig_byte = 8'h0A;
      4'd4: sig_byte = 8'h00;
      4'd5: sig_byte = 8'h0D;
      4'd6: sig_byte = 8'h0A;
      4'd7: sig_byte = 8'h51;
      4'd8: sig_byte = 8'h55;
      4'd9: sig_byte = 8'h49;
      4'd10: sig_byte = 8'h54;
      4'd11: sig_byte = 8'h0A;
      default: sig_byte = 8'h00;
    endcase
  endfunction

  // raw input beat handed to the front parser
  typedef struct packed {
    logic [7:0]  data;
    logic        first;
    logic        last;
  } item_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] offset;
    logic [7:0]  data;
    logic [3:0]  status;
    logic        done;
    logic [16:0] hlen;
    logic [1:0]  fam;
    logic        dgram;
  } result_t;

endpackage

FILE: design/phv2_front.sv
// Parser state machine: one byte per cycle while valid is high, produces a tagged result.
module phv2_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              valid,
  input  phv2_pkg::item_t   item,
  output phv2_pkg::result_t res
);
  import phv2_pkg::*;

  logic [16:0] cnt_r, cnt_nxt;
  logic [7:0]  cmd_r, cmd_nxt, fam_r, fam_nxt, hold_r, hold_nxt;
  logic [15:0] blen_r, blen_nxt, left_r, left_nxt, vpos_r, vpos_nxt;
  logic [1:0]  ph_r, ph_nxt;
  logic [3:0]  perr_r, perr_nxt;
  logic        fin_r, fin_nxt;

  always_comb begin
    logic [16:0] pos, total, p, rem, alen, seg, need;
    logic [15:0] len;
    logic [3:0]  kind;
    logic [15:0] off;
    logic        done;
    logic [3:0]  st;
    logic [7:0]  b;
    b = item.data;
    cnt_nxt = cnt_r; cmd_nxt = cmd_r; fam_nxt = fam_r; hold_nxt = hold_r;
    blen_nxt = blen_r; left_nxt = left_r; vpos_nxt = vpos_r; ph_nxt = ph_r;
    perr_nxt = perr_r; fin_nxt = fin_r;
    if (item.first) begin
      cnt_nxt = '0; cmd_nxt = '0; fam_nxt = '0; hold_nxt = '0; blen_nxt = '0;
      left_nxt = '0; vpos_nxt = '0; ph_nxt = '0; perr_nxt = '0; fin_nxt = 1'b0;
    end
    kind = K_PAY; off = '0; done = 1'b0;
    pos = cnt_nxt;
    total = FIXED_LEN + {1'b0, blen_nxt};
    p = pos - FIXED_LEN;
    rem = total - pos;
    len = {hold_nxt, b};
    if (fam_nxt[7:4] == 4'd1) begin
      alen = ADDR_LEN_V4; seg = 17'd4;
    end else begin
      alen = ADDR_LEN_V6; seg = 17'd16;
    end
    need = alen;
    if (!fin_nxt) begin
      if (pos < 17'd12) begin
        kind = K_SIG; off = pos[15:0];
        if (b != sig_byte(pos[3:0])) begin
          perr_nxt = S_NOSIG; fin_nxt = 1'b1; done = 1'b1;
        end
      end else if (pos == 17'd12) begin
        kind = K_CMD; cmd_nxt = b;
        if (b != CMD_LOCAL && b != CMD_PROXY) perr_nxt = S_BADCMD;
      end else if (pos == 17'd13) begin
        kind = K_FAM; fam_nxt = b;
        if (perr_nxt == S_PEND) begin
          if (cmd_nxt == CMD_LOCAL) begin
            if (b != FAM_UNSPEC) perr_nxt = S_BADFAM;
          end else if (b != FAM_TCP4 && b != FAM_UDP4 && b != FAM_TCP6 &&
                       b != FAM_UDP6) begin
            perr_nxt = S_BADFAM;
          end
        end
      end else if (pos == 17'd14) begin
        kind = K_LEN; blen_nxt = {b, 8'h00};
      end else if (pos == 17'd15) begin
        kind = K_LEN; off = 16'd1;
        blen_nxt = {blen_nxt[15:8], b};
        if (perr_nxt == S_PEND && cmd_nxt == CMD_PROXY &&
            {1'b0, blen_nxt} < need) perr_nxt = S_SHORT;
      end else if (perr_nxt != S_PEND || cmd_nxt != CMD_PROXY) begin
        kind = K_IGN; off = p[15:0];
      end else if (p < alen) begin
        if (p < seg) begin
          kind = K_SRC; off = p[15:0];
        end else if (p < (seg << 1)) begin
          kind = K_DST; off = 16'(p - seg);
        end else if (p < (seg << 1) + 17'd2) begin
          kind = K_SPORT; off = 16'(p - (seg << 1));
        end else begin
          kind = K_DPORT; off = 16'(p - (seg << 1) - 17'd2);
        end
      end else begin
        case (ph_nxt)
          2'd0: begin
            kind = K_TTYPE;
            if (rem < 17'd3) perr_nxt = S_TLVSHORT;
            else ph_nxt = 2'd1;
          end
          2'd1: begin
            kind = K_TLEN; hold_nxt = b; ph_nxt = 2'd2;
          end
          2'd2: begin
            kind = K_TLEN; off = 16'd1;
            if (rem - 17'd1 < {1'b0, len}) begin
              perr_nxt = S_TLVOVR; ph_nxt = 2'd0;
            end else if (len == 16'd0) begin
              ph_nxt = 2'd0;
            end else begin
              ph_nxt = 2'd3; left_nxt = len; vpos_nxt = '0;
            end
          end
          default: begin
            kind = K_TVAL; off = vpos_nxt;
            vpos_nxt = vpos_nxt + 16'd1;
            left_nxt = left_nxt - 16'd1;
            if (left_nxt == 16'd0) ph_nxt = 2'd0;
          end
        endcase
      end
      if (!fin_nxt) begin
        cnt_nxt = pos + 17'd1;
        if (pos >= 17'd15 && cnt_nxt == FIXED_LEN + {1'b0, blen_nxt}) begin
          if (perr_nxt == S_PEND) perr_nxt = (cmd_nxt == CMD_PROXY) ? S_PROXY : S_LOCAL;
          fin_nxt = 1'b1; done = 1'b1;
        end else if (item.last) begin
          perr_nxt = S_TRUNC; fin_nxt = 1'b1; done = 1'b1;
        end
      end
    end
    st = fin_nxt ? perr_nxt : S_PEND;
    res.kind = kind;
    res.offset = off;
    res.data = b;
    res.status = st;
    res.done = done;
    res.hlen = (st == S_PROXY || st == S_LOCAL) ? cnt_nxt : '0;
    res.fam = (fam_nxt[7:4] == 4'd1) ? 2'd1 : (fam_nxt[7:4] == 4'd2) ? 2'd2 : 2'd0;
    res.dgram = (fam_nxt == FAM_UDP4 || fam_nxt == FAM_UDP6);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; cmd_r <= '0; fam_r <= '0; hold_r <= '0; blen_r <= '0;
      left_r <= '0; vpos_r <= '0; ph_r <= '0; perr_r <= '0; fin_r <= 1'b0;
    end else if (valid) begin
      cnt_r <= cnt_nxt; cmd_r <= cmd_nxt; fam_r <= fam_nxt; hold_r <= hold_nxt;
      blen_r <= blen_nxt; left_r <= left_nxt; vpos_r <= vpos_nxt; ph_r <= ph_nxt;
      perr_r <= perr_nxt; fin_r <= fin_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    res.done |-> res.status != S_PEND) else $error("done without final status");
  assert property (@(posedge clk) disable iff (!rst_n)
    (res.hlen != '0) |-> (res.status == S_PROXY || res.status == S_LOCAL))
    else $error("length on failed header");
  assert property (@(posedge clk) disable iff (!rst_n)
    fin_r && !item.first |-> res.kind == K_PAY) else $error("tag after finish");
endmodule

FILE: design/phv2_queue.sv
// Result queue between the parser and the output side.
module phv2_queue #(
  parameter int unsigned DEPTH = phv2_pkg::QDepthDefault
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr,
  input  phv2_pkg::result_t wdata,
  input  logic              rd,
  output phv2_pkg::result_t rdata,
  output logic              full,
  output logic              empty
);
  import phv2_pkg::*;
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  result_t mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  assign full  = (cnt_r == (AW+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (rd) rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    !(wr && full)) else $error("queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    !(rd && empty)) else $error("queue underflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    wr && !rd |=> !empty) else $error("write lost");
endmodule

FILE: design/proxy_header_v2_binary_parser_unit.sv
// A byte's result is written into the result queue when the byte is accepted and is read at the queue head.
// One byte per cycle is accepted while the queue is not full; the parser state updates on each accepted byte.
// The result queue lets input continue while results wait, up to QDEPTH.
// Reset (rst_n low, synchronous) clears parser state and empties the queue.
module proxy_header_v2_binary_parser_unit #(
  parameter int unsigned QDEPTH = phv2_pkg::QDepthDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_first_byte,
  input  logic        in_last_byte,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  out_field_kind,
  output logic [15:0] out_field_offset,
  output logic [7:0]  out_byte_out,
  output logic [3:0]  out_status,
  output logic        out_header_done,
  output logic [16:0] out_header_length,
  output logic [1:0]  out_addr_family,
  output logic        out_is_datagram
);
  import phv2_pkg::*;

  item_t   item;
  result_t res, q;
  logic    acc;

  assign item = '{data: in_data_byte, first: in_first_byte, last: in_last_byte};
  assign acc  = push && !full;

  phv2_front u_front (.clk, .rst_n, .valid(acc), .item, .res);

  phv2_queue #(.DEPTH(QDEPTH)) u_q (
    .clk, .rst_n, .wr(acc), .wdata(res), .rd(pop && !empty), .rdata(q),
    .full, .empty
  );

  assign out_field_kind    = q.kind;
  assign out_field_offset  = q.offset;
  assign out_byte_out      = q.data;
  assign out_status        = q.status;
  assign out_header_done   = q.done;
  assign out_header_length = q.hlen;
  assign out_addr_family   = q.fam;
  assign out_is_datagram   = q.dgram;
endmodule
